// ----- rtl/complex_int16_matrix_multiply_defines.svh -----
// assertion macros for the complex matrix multiply block
// used by complex_int16_matrix_multiply.sv; no other dependencies
`ifndef COMPLEX_INT16_MATRIX_MULTIPLY_DEFINES_SVH
`define COMPLEX_INT16_MATRIX_MULTIPLY_DEFINES_SVH
`ifndef SYNTHESIS
`define CIMM_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cimm assertion failed");
`define CIMM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cimm assertion failed");
`else
`define CIMM_ASSERT_IMP(name, clk, rst, ante, cons)
`define CIMM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/cimm_pkg.sv -----
// shared types and constants of the complex matrix multiply block
// no dependencies
`timescale 1ns / 1ps
package cimm_pkg;
   localparam int CMD_W     = 2;
   localparam int ROW_W     = 3;
   localparam int VALUE_W   = 16;
   localparam int SUM_W     = 32;
   localparam int DIM_W     = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   // bookkeeping that travels with one multiply-accumulate step
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] col;
      logic             first;  // first step of an element, restart the sum
      logic             fin;    // final step of an element, emit the sum
      logic             zero;   // empty inner dimension, contribute nothing
      logic             last;   // final element of the product
   } tag_type;
endpackage

// ----- rtl/cimm_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module cimm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/cimm_cmac.sv -----
// pipelined complex multiply-accumulate unit: multiply, combine, accumulate
// depends on cimm_pkg
`timescale 1ns / 1ps
module cimm_cmac #(
   parameter int ELEM_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  cimm_pkg::tag_type                   in_tag,
   input  logic signed [ELEM_WIDTH-1:0]        a_re,
   input  logic signed [ELEM_WIDTH-1:0]        a_im,
   input  logic signed [ELEM_WIDTH-1:0]        b_re,
   input  logic signed [ELEM_WIDTH-1:0]        b_im,
   output logic                                out_valid,
   output logic [cimm_pkg::ROW_W-1:0]          out_row,
   output logic [cimm_pkg::ROW_W-1:0]          out_col,
   output logic signed [cimm_pkg::SUM_W-1:0]   out_sum_re,
   output logic signed [cimm_pkg::SUM_W-1:0]   out_sum_im,
   output logic                                out_last,
   output logic                                active
);
   import cimm_pkg::*;

   localparam int PROD_W = 2 * ELEM_WIDTH;

   // products
   logic                     p_v_ff;
   tag_type                  p_tag_ff;
   logic signed [PROD_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [PROD_W-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in;

   // combined terms
   logic                    t_v_ff;
   tag_type                 t_tag_ff;
   logic signed [SUM_W-1:0] t_re_ff, t_im_ff;
   logic signed [SUM_W-1:0] t_re_in, t_im_in;

   // accumulator and result
   logic signed [SUM_W-1:0] acc_re_ff, acc_im_ff;
   logic signed [SUM_W-1:0] acc_re_in, acc_im_in;
   logic                    out_valid_ff;
   logic [ROW_W-1:0]        out_row_ff, out_col_ff;
   logic signed [SUM_W-1:0] out_re_ff, out_im_ff;
   logic                    out_last_ff;

   assign p_rr_in = a_re * b_re;
   assign p_ii_in = a_im * b_im;
   assign p_ri_in = a_re * b_im;
   assign p_ir_in = a_im * b_re;

   always_comb begin
      if (p_tag_ff.zero) begin
         t_re_in = '0;
         t_im_in = '0;
      end else begin
         t_re_in = SUM_W'(p_rr_ff) - SUM_W'(p_ii_ff);
         t_im_in = SUM_W'(p_ri_ff) + SUM_W'(p_ir_ff);
      end
   end

   always_comb begin
      acc_re_in = (t_tag_ff.first ? '0 : acc_re_ff) + t_re_ff;
      acc_im_in = (t_tag_ff.first ? '0 : acc_im_ff) + t_im_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff       <= 1'b0;
         t_v_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p_v_ff       <= in_valid;
         t_v_ff       <= p_v_ff;
         out_valid_ff <= t_v_ff && t_tag_ff.fin;
      end
   end

   always_ff @(posedge clock) begin
      p_tag_ff <= in_tag;
      p_rr_ff  <= p_rr_in;
      p_ii_ff  <= p_ii_in;
      p_ri_ff  <= p_ri_in;
      p_ir_ff  <= p_ir_in;
      t_tag_ff <= p_tag_ff;
      t_re_ff  <= t_re_in;
      t_im_ff  <= t_im_in;
      if (t_v_ff) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
      if (t_v_ff && t_tag_ff.fin) begin
         out_row_ff  <= t_tag_ff.row;
         out_col_ff  <= t_tag_ff.col;
         out_re_ff   <= acc_re_in;
         out_im_ff   <= acc_im_in;
         out_last_ff <= t_tag_ff.last;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_row    = out_row_ff;
   assign out_col    = out_col_ff;
   assign out_sum_re = out_re_ff;
   assign out_sum_im = out_im_ff;
   // last only shows alongside its result
   assign out_last   = out_last_ff & out_valid_ff;
   assign active     = p_v_ff | t_v_ff;
endmodule

// ----- rtl/complex_int16_matrix_multiply.sv -----
// top level of the complex matrix multiply block: command decode, element
// stores, step sequencer; depends on cimm_pkg, cimm_ram, cimm_cmac and the defines header
`timescale 1ns / 1ps
`include "complex_int16_matrix_multiply_defines.svh"
// usage
//  - an item is taken at a clock edge with start high and busy low
//  - write A / write B items store one complex element at (row, col); a row
//    or col at MAX_DIM or beyond is dropped
//  - a compute item raises busy and streams the product row-major, one result
//    per element, each shown for one cycle with rsp_valid; rsp_last marks the
//    final element of the product
//  - one complex multiply-accumulate unit serves every step, one step a cycle;
//    a compute runs rows_a * cols_b * max(inner_len, 1) steps and holds busy
//    until the last has drained from the pipeline of that single shared unit
//  - rows_a or cols_b at zero: compute emits nothing and does not raise busy
//  - dimension registers above MAX_DIM act as MAX_DIM; the user must write
//    them over csr_* only while busy is low; the block does not enforce it
//  - reset sets all dimensions to 8 and empties the pipeline; the element
//    stores are not cleared and must be written before use
//  - the receiver cannot stall results; no backpressure exists
module complex_int16_matrix_multiply #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // command channel
   input  logic                                  start,
   output logic                                  busy,
   input  logic [cimm_pkg::CMD_W-1:0]            req_command,
   input  logic [cimm_pkg::ROW_W-1:0]            req_row,
   input  logic [cimm_pkg::ROW_W-1:0]            req_col,
   input  logic signed [cimm_pkg::VALUE_W-1:0]   req_value_re,
   input  logic signed [cimm_pkg::VALUE_W-1:0]   req_value_im,
   // result channel
   output logic                                  rsp_valid,
   output logic [cimm_pkg::ROW_W-1:0]            rsp_out_row,
   output logic [cimm_pkg::ROW_W-1:0]            rsp_out_col,
   output logic signed [cimm_pkg::SUM_W-1:0]     rsp_sum_re,
   output logic signed [cimm_pkg::SUM_W-1:0]     rsp_sum_im,
   output logic                                  rsp_last,
   // register write port
   input  logic                                  csr_wr_en,
   input  logic [cimm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cimm_pkg::DIM_W-1:0]            csr_wdata
);
   import cimm_pkg::*;

   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WORD_W = 2 * ELEM_WIDTH;
   localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIM);

   // dimension registers
   logic [DIM_W-1:0] rows_a_ff, inner_len_ff, cols_b_ff;
   logic [DIM_W-1:0] dim_m, dim_n, dim_o;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_W'(8);
         inner_len_ff <= DIM_W'(8);
         cols_b_ff    <= DIM_W'(8);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_A:    rows_a_ff    <= csr_wdata;
            CSR_INNER_LEN: inner_len_ff <= csr_wdata;
            CSR_COLS_B:    cols_b_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // saturate oversized dimensions
   assign dim_m = (rows_a_ff > MaxDim)    ? MaxDim : rows_a_ff;
   assign dim_n = (inner_len_ff > MaxDim) ? MaxDim : inner_len_ff;
   assign dim_o = (cols_b_ff > MaxDim)    ? MaxDim : cols_b_ff;

   // command decode
   logic accept, in_range, wr_a, wr_b, go;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_word;

   assign accept   = start && !busy;
   assign in_range = ({1'b0, req_row} < (ROW_W+1)'(MAX_DIM))
                  && ({1'b0, req_col} < (ROW_W+1)'(MAX_DIM));
   assign wr_a     = accept && in_range && (req_command == CMD_WRITE_A);
   assign wr_b     = accept && in_range && (req_command == CMD_WRITE_B);
   assign go       = accept && (req_command == CMD_COMPUTE)
                  && (dim_m != '0) && (dim_o != '0);
   assign wr_addr  = ADDR_W'(req_row) * ADDR_W'(MAX_DIM) + ADDR_W'(req_col);
   assign wr_word  = {req_value_im[ELEM_WIDTH-1:0], req_value_re[ELEM_WIDTH-1:0]};

   // step sequencer: m outer, o middle, n inner
   logic             run_ff, run_in;
   logic [IDX_W-1:0] m_ff, m_in, o_ff, o_in, n_ff, n_in;
   logic             zero_n, last_n, last_o, last_m;
   tag_type          step_tag;
   logic [ADDR_W-1:0] addr_a, addr_b;

   assign zero_n = (dim_n == '0);
   assign last_n = zero_n || ((DIM_W'(n_ff) + DIM_W'(1)) == dim_n);
   assign last_o = (DIM_W'(o_ff) + DIM_W'(1)) == dim_o;
   assign last_m = (DIM_W'(m_ff) + DIM_W'(1)) == dim_m;

   always_comb begin
      run_in = run_ff;
      m_in   = m_ff;
      o_in   = o_ff;
      n_in   = n_ff;
      if (go) begin
         run_in = 1'b1;
         m_in   = '0;
         o_in   = '0;
         n_in   = '0;
      end else if (run_ff) begin
         if (!last_n) begin
            n_in = n_ff + IDX_W'(1);
         end else begin
            n_in = '0;
            if (!last_o) begin
               o_in = o_ff + IDX_W'(1);
            end else begin
               o_in = '0;
               if (last_m) begin
                  run_in = 1'b0;
               end else begin
                  m_in = m_ff + IDX_W'(1);
               end
            end
         end
      end
   end

   always_comb begin
      step_tag.row   = ROW_W'(m_ff);
      step_tag.col   = ROW_W'(o_ff);
      step_tag.first = (n_ff == '0);
      step_tag.fin   = last_n;
      step_tag.zero  = zero_n;
      step_tag.last  = last_n && last_o && last_m;
   end

   assign addr_a = ADDR_W'(m_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(n_ff);
   assign addr_b = ADDR_W'(n_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(o_ff);

   // read stage aligned with the registered ram output
   logic    s1_v_ff;
   tag_type s1_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         s1_v_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         s1_v_ff <= run_ff;
      end
   end

   always_ff @(posedge clock) begin
      m_ff      <= m_in;
      o_ff      <= o_in;
      n_ff      <= n_in;
      s1_tag_ff <= step_tag;
   end

   // element stores: re in the low half, im in the high half
   logic [WORD_W-1:0] word_a, word_b;

   cimm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_addr (addr_a),
      .rd_data (word_a)
   );

   cimm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_addr (addr_b),
      .rd_data (word_b)
   );

   // shared complex multiply-accumulate unit
   logic mac_active;

   cimm_cmac #(.ELEM_WIDTH(ELEM_WIDTH)) u_cmac (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_v_ff),
      .in_tag     (s1_tag_ff),
      .a_re       (signed'(word_a[ELEM_WIDTH-1:0])),
      .a_im       (signed'(word_a[WORD_W-1:ELEM_WIDTH])),
      .b_re       (signed'(word_b[ELEM_WIDTH-1:0])),
      .b_im       (signed'(word_b[WORD_W-1:ELEM_WIDTH])),
      .out_valid  (rsp_valid),
      .out_row    (rsp_out_row),
      .out_col    (rsp_out_col),
      .out_sum_re (rsp_sum_re),
      .out_sum_im (rsp_sum_im),
      .out_last   (rsp_last),
      .active     (mac_active)
   );

   // busy until every step has left the accumulator
   assign busy = run_ff | s1_v_ff | mac_active;

   // checks
   `CIMM_ASSERT_IMP(a_rsp_after_work, clock, reset, rsp_valid, $past(busy))
   `CIMM_ASSERT_IMP(a_last_is_valid, clock, reset, rsp_last, rsp_valid)
   `CIMM_ASSERT_NEXT(a_compute_busy, clock, reset, go, busy)
   `CIMM_ASSERT_IMP(a_step_in_range, clock, reset, run_ff, (DIM_W'(m_ff) < dim_m) && (DIM_W'(o_ff) < dim_o))
endmodule
